// File: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hash block.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 61;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned RND_W    = $clog2(ROUNDS);
    localparam int unsigned BLOCK_W  = 512;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [2:0]  LAST_IDX = 3'd7;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_BYTE,
        WIN_LEN,
        WIN_ROUND
    } t_win_op;

    typedef struct packed {
        logic             init;
        logic             load;
        logic             round;
        logic             fold;
        logic [RND_W-1:0] rnd;
    } t_core_ctl;

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: src/sha_sched.sv
// ----------------------------------------------------------------------------
// sha_sched
// Block buffer and rolling message schedule: bytes and the length shift in,
// and during the rounds the window advances one word per cycle.
// ----------------------------------------------------------------------------
module sha_sched (
    input  logic            i_clk,
    input  sha_pkg::t_win_op i_op,
    input  logic [7:0]      i_byte,
    input  logic [63:0]     i_len,
    output logic [31:0]     o_w
);
    import sha_pkg::*;

    // word 0 (the oldest) sits in the top bits
    logic [BLOCK_W-1:0] r_win;
    logic [BLOCK_W-1:0] n_win;
    logic [31:0]        w_new;

    assign w_new = r_win[511:480] + small_s0(r_win[479:448])
                 + r_win[223:192] + small_s1(r_win[63:32]);

    always_comb begin
        unique case (i_op)
            WIN_HOLD:  n_win = r_win;
            WIN_BYTE:  n_win = {r_win[BLOCK_W-9:0], i_byte};
            WIN_LEN:   n_win = {r_win[BLOCK_W-65:0], i_len};
            WIN_ROUND: n_win = {r_win[BLOCK_W-33:0], w_new};
            default:   n_win = r_win;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_w = r_win[511:480];

endmodule

// File: src/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Compression round unit: working variables, one round per cycle, and the
// chaining value with its fold at the end of each block.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    input  logic [31:0]        i_w,
    input  logic [2:0]         i_idx,
    output logic [31:0]        o_digest
);
    import sha_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    always_comb begin
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + big_s1(r_v[4]) + ch + ROUND_K[i_ctl.rnd] + i_w;
        t2 = big_s0(r_v[0]) + mj;
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= HASH_IV;
        end else if (i_ctl.init) begin
            r_h <= HASH_IV;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_h;
        end else if (i_ctl.round) begin
            r_v <= n_v;
        end
    end

    assign o_digest = r_h[i_idx];

endmodule

// File: src/sha256_hash.sv
// ----------------------------------------------------------------------------
// sha256_hash
// Streaming SHA-256: message bytes in, eight digest words out.
// ----------------------------------------------------------------------------
// Input channel: one word per accepted item (i_valid high, o_stall low),
// carrying an optional message byte and an end-of-message flag. An item with
// no byte and no end flag is taken and has no effect.
// Bytes enter the block buffer at one per cycle while o_stall is low. The 64th byte
// of a block starts a compression on the single round unit: a load, 64 rounds
// and a fold, during all of which o_stall is high and no byte is taken.
// On the end flag the block shifts in the 0x80 marker and zero fill at one
// byte per cycle, then the 64-bit length as a whole, and compresses one or
// two closing blocks. The digest then appears on the output channel, word 0
// first, one word per cycle while i_stall is low; a stalled word holds.
// No input is taken from the end flag until word 7 has gone.
// After word 7 the chaining value returns to the initial hash values.
// Reset (synchronous, active low) loads the initial hash values, clears the
// byte count and leaves the block ready for a new message.
// ----------------------------------------------------------------------------
module sha256_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    t_state              r_state, n_state;
    logic [5:0]          r_fill, n_fill;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [RND_W-1:0]    r_rnd, n_rnd;
    logic [2:0]          r_idx, n_idx;
    logic                r_closing, n_closing;
    logic                r_mark, n_mark;
    logic                r_final, n_final;

    t_win_op             win_op;
    logic [7:0]          win_byte;
    t_core_ctl           core_ctl;
    logic [31:0]         w_t;
    logic [31:0]         digest;
    logic                in_acc;

    assign in_acc = i_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_count   = r_count;
        n_rnd     = r_rnd;
        n_idx     = r_idx;
        n_closing = r_closing;
        n_mark    = r_mark;
        n_final   = r_final;
        win_op    = WIN_HOLD;
        win_byte  = i_data.byte_value;
        core_ctl  = '{init: 1'b0, load: 1'b0, round: 1'b0, fold: 1'b0, rnd: r_rnd};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_data.is_last) begin
                        n_closing = 1'b1;
                        n_state   = ST_PAD;
                    end
                    if (i_data.has_byte) begin
                        win_op  = WIN_BYTE;
                        n_fill  = r_fill + 6'd1;
                        n_count = r_count + 61'd1;
                        if (r_fill == LAST_POS) begin
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                priority if (!r_mark) begin
                    win_op   = WIN_BYTE;
                    win_byte = PAD_BYTE;
                    n_mark   = 1'b1;
                    n_fill   = r_fill + 6'd1;
                    if (r_fill == LAST_POS) begin
                        n_state = ST_LOAD;
                    end
                end else if (r_fill == LEN_POS) begin
                    win_op  = WIN_LEN;
                    n_fill  = r_fill + 6'd8;
                    n_final = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    win_op   = WIN_BYTE;
                    win_byte = 8'h00;
                    n_fill   = r_fill + 6'd1;
                    if (r_fill == LAST_POS) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                core_ctl.load = 1'b1;
                n_rnd         = '0;
                n_state       = ST_ROUND;
            end
            ST_ROUND: begin
                core_ctl.round = 1'b1;
                win_op         = WIN_ROUND;
                n_rnd          = r_rnd + 1'b1;
                if (r_rnd == RND_W'(ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctl.fold = 1'b1;
                priority if (r_final) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else if (r_closing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_IDX) begin
                        core_ctl.init = 1'b1;
                        n_count       = '0;
                        n_closing     = 1'b0;
                        n_mark        = 1'b0;
                        n_final       = 1'b0;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_count   <= '0;
            r_rnd     <= '0;
            r_idx     <= '0;
            r_closing <= 1'b0;
            r_mark    <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_count   <= n_count;
            r_rnd     <= n_rnd;
            r_idx     <= n_idx;
            r_closing <= n_closing;
            r_mark    <= n_mark;
            r_final   <= n_final;
        end
    end

    sha_sched u_sched (
        .i_clk  (i_clk),
        .i_op   (win_op),
        .i_byte (win_byte),
        .i_len  ({r_count, 3'b000}),
        .o_w    (w_t)
    );

    sha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_w      (w_t),
        .i_idx    (r_idx),
        .o_digest (digest)
    );

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = (r_state == ST_OUT);
    assign o_data.digest_word = digest;
    assign o_data.word_index  = r_idx;
    assign o_data.last_word   = (r_idx == LAST_IDX);

endmodule

// File: src/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input sha_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input sha_pkg::t_out o_data
);
    import sha_pkg::*;

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("digest word changed under stall");

    // no input is taken while the digest is being sent
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while digest pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == LAST_IDX)))
        else $error("last_word does not match word index");

    // words follow one another without gaps until the last one
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word
        |=> o_valid && (o_data.word_index == $past(o_data.word_index) + 3'd1))
        else $error("digest word missing or out of order");

    a_end_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_data.last_word |=> !o_valid && !o_stall)
        else $error("block not idle after last digest word");

endmodule

bind sha256_hash sha_checker u_sha_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming SHA-256 block against a behavioural hash model. A short
// table of directed items (empty message, the "abc" vector, byte extremes and
// empty items) runs first. Random messages follow, with lengths around the
// block and padding boundaries, random gaps and stalls on both channels, and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam int RAND_ITEMS = 205;
    localparam int HOLD_LEN   = 400;
    localparam int WATCHDOG   = 4000;
    localparam int DRAIN_WAIT = 200;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct {
        t_in          item;
        bit           known;
        logic [255:0] digest;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    // behavioural hash state
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [60:0] msg_len;

    t_out digest_q [$];

    // known digest for the word currently offered, read at the accepting edge
    bit           cur_known;
    logic [255:0] cur_digest;
    // bumped by the stimulus each time it wants a long output hold-off
    int           hold_cnt = 0;

    int errors = 0;
    int idle_cycles = 0;
    int n_msgs = 0;
    int n_bytes = 0;
    int n_two_blk = 0;
    int n_words = 0;

    sha256_hash u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_restart();
        foreach (hv[k]) hv[k] = HASH_IV[k];
        foreach (blk[k]) blk[k] = '0;
        msg_len = '0;
    endfunction

    function automatic void put_byte(input int pos, input logic [7:0] b);
        blk[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w[r] = blk[r];
            end else begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    // absorb one word; on the end flag pad, finish and hand back the digest
    function automatic bit hash_take(input t_in d, output logic [255:0] dig);
        int          pos;
        logic [63:0] nbits;
        dig = '0;
        if (d.has_byte) begin
            pos = int'(msg_len[5:0]);
            put_byte(pos, d.byte_value);
            msg_len = msg_len + 61'd1;
            n_bytes++;
            if (pos == 63) sha_compress();
        end
        if (!d.is_last) return 1'b0;
        pos = int'(msg_len[5:0]);
        put_byte(pos, PAD_BYTE);
        for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
        if (pos >= 56) begin
            // length does not fit: extra closing block
            sha_compress();
            foreach (blk[k]) blk[k] = '0;
            n_two_blk++;
        end
        nbits   = {msg_len, 3'b000};
        blk[14] = nbits[63:32];
        blk[15] = nbits[31:0];
        sha_compress();
        for (int k = 0; k < 8; k++) dig[255 - 32*k -: 32] = hv[k];
        n_msgs++;
        hash_restart();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : score
        bit           moved;
        logic [255:0] dig;
        t_out         want;
        t_out         got;
        if (!i_rst_n) begin
            hash_restart();
        end else begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                if (hash_take(i_data, dig)) begin
                    if (cur_known) dig = cur_digest;
                    for (int k = 0; k < 8; k++) begin
                        want.digest_word = dig[255 - 32*k -: 32];
                        want.word_index  = 3'(k);
                        want.last_word   = (3'(k) == LAST_IDX);
                        digest_q.insert(digest_q.size(), want);
                    end
                end
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                n_words++;
                got = o_data;
                if (digest_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h/%0d/%0b",
                             $time, got.digest_word, got.word_index, got.last_word);
                end else begin
                    want = digest_q.pop_front();
                    if (got.digest_word !== want.digest_word) begin
                        errors++;
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, want.digest_word, got.digest_word);
                    end
                    if (got.word_index !== want.word_index) begin
                        errors++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.word_index, got.word_index);
                    end
                    if (got.last_word !== want.last_word) begin
                        errors++;
                        $display("%0t: last_word expected %0b actual %0b",
                                 $time, want.last_word, got.last_word);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // output side: runs of ready and stall, plus one long hold-off on request
    initial begin : sink
        int stall_left;
        int ready_left;
        int r;
        int hold_seen;
        stall_left = 0;
        ready_left = 0;
        hold_seen  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt != hold_seen) begin
                hold_seen  = hold_cnt;
                stall_left = HOLD_LEN;
                ready_left = 0;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (ready_left > 0) begin
                i_stall <= 1'b0;
                ready_left--;
            end else begin
                i_stall <= 1'b0;
                r = $urandom_range(0, 99);
                ready_left = (r < 10) ? $urandom_range(50, 150) : $urandom_range(0, 20);
                r = $urandom_range(0, 99);
                if (r < 70)      stall_left = $urandom_range(1, 3);
                else if (r < 90) stall_left = 0;
                else             stall_left = $urandom_range(20, 60);
            end
        end
    end

    function automatic int pick_gap(input bit no_gap);
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer(input t_in d, input bit known, input logic [255:0] dig,
                         input bit no_gap);
        int gap;
        cur_known  = known;
        cur_digest = dig;
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap(no_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // one message of len bytes with random content; returns words that count
    task automatic send_message(input int len, output int used);
        bit  no_gap;
        bit  sep_close;
        t_in d;
        no_gap    = ($urandom_range(0, 3) == 0);
        sep_close = (len == 0) || ($urandom_range(0, 1) == 1);
        used      = len + (sep_close ? 1 : 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                d = '{byte_value: 8'($urandom), has_byte: 1'b0, is_last: 1'b0};
                offer(d, 1'b0, '0, no_gap);
            end
            d = '{byte_value: 8'($urandom), has_byte: 1'b1,
                  is_last: (i == len - 1) && !sep_close};
            offer(d, 1'b0, '0, no_gap);
        end
        if (sep_close) begin
            d = '{byte_value: 8'($urandom), has_byte: 1'b0, is_last: 1'b1};
            offer(d, 1'b0, '0, no_gap);
        end
    endtask

    function automatic t_row row(input logic [7:0] b, input bit hb, input bit lst,
                                 input bit known = 1'b0, input logic [255:0] dig = '0);
        t_row x;
        x.item   = '{byte_value: b, has_byte: hb, is_last: lst};
        x.known  = known;
        x.digest = dig;
        return x;
    endfunction

    initial begin : stimulus
        t_row rows [$];
        int   sent;
        int   used;
        int   len;
        int   msg_no;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        cur_known  = 1'b0;
        cur_digest = '0;

        rows.insert(rows.size(), row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST));
        rows.insert(rows.size(), row(8'h5a, 1'b0, 1'b0));
        rows.insert(rows.size(), row(8'h61, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'hff, 1'b0, 1'b0));
        rows.insert(rows.size(), row(8'h62, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST));
        rows.insert(rows.size(), row(8'hff, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'h00, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'hff, 1'b1, 1'b1));
        rows.insert(rows.size(), row(8'h00, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'h80, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'h7f, 1'b1, 1'b0));
        rows.insert(rows.size(), row(8'h00, 1'b0, 1'b1));
        rows.insert(rows.size(), row(8'hff, 1'b1, 1'b1));
        rows.insert(rows.size(), row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) offer(rows[k].item, rows[k].known, rows[k].digest, 1'b0);

        // let every digest drain before the random part
        while (digest_q.size() != 0) @(negedge i_clk);

        sent   = 0;
        msg_no = 0;
        while (sent < RAND_ITEMS) begin
            if (msg_no == 3) begin
                // output held off while a two-block message and more keep coming
                hold_cnt++;
                send_message(70, used);
            end else begin
                if ($urandom_range(0, 99) < 80) begin
                    len = $urandom_range(0, 12);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       len = 55;
                        1:       len = 56;
                        2:       len = 63;
                        default: len = 64;
                    endcase
                end
                send_message(len, used);
            end
            sent += used;
            msg_no++;
        end
        i_valid <= 1'b0;

        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("covered %0d messages (%0d with two closing blocks), %0d message bytes",
                 n_msgs, n_two_blk, n_bytes);
        $display("%0d digest words checked, %0d mismatches", n_words, errors);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
